// File: hw/rtl/fmvb_pkg.sv
package fmvb_pkg;

    // input command codes
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_TRIGGER = 2'd1,
        CMD_LOAD    = 2'd2
    } cmd_t;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ENV_STEP_MOD = 2'd0;
    localparam logic [1:0] REG_ENV_STEP_CAR = 2'd1;
    localparam logic [1:0] REG_OUTPUT_GAIN  = 2'd2;

    // register reset values
    localparam logic [24:0] ENV_STEP_MOD_RST = 25'd3804;
    localparam logic [24:0] ENV_STEP_CAR_RST = 25'd380;
    localparam logic [15:0] OUTPUT_GAIN_RST  = 16'd4369;

    // fixed point
    localparam int ENV_W  = 25;
    localparam int GAIN_W = 17;
    localparam logic [ENV_W-1:0]  ENV_FULL = 25'h100_0000;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 17'h1_0000;

    // 2^32 / (2*pi), rounded
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    // sine polynomial coefficients, Q15
    localparam longint unsigned SIN_A = 64'd51472;
    localparam longint unsigned SIN_B = 64'd21024;
    localparam longint unsigned SIN_C = 64'd2320;

    // sequencer states
    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_ENV  = 10'b00_0000_0010,
        S_MMUL = 10'b00_0000_0100,
        S_OFF  = 10'b00_0000_1000,
        S_ANG  = 10'b00_0001_0000,
        S_CMUL = 10'b00_0010_0000,
        S_GAIN = 10'b00_0100_0000,
        S_ACC  = 10'b00_1000_0000,
        S_MIX  = 10'b01_0000_0000,
        S_SAT  = 10'b10_0000_0000
    } state_t;

endpackage

// File: hw/rtl/fmvb_sine_rom.sv
module fmvb_sine_rom #(
    parameter int SINE_DEPTH = 1024,
    localparam int IDX_W = $clog2(SINE_DEPTH)
) (
    input  logic               clk,
    input  logic [IDX_W-1:0]   addr,
    output logic signed [15:0] data
);
    import fmvb_pkg::*;

    // full-wave table built at elaboration from a quarter-wave polynomial
    function automatic logic [SINE_DEPTH-1:0][15:0] build_table();
        logic [SINE_DEPTH-1:0][15:0] tab;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned t;
        tab = '0;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            q   = (longint'(k) * 4) / SINE_DEPTH;
            rem = (longint'(k) * 4) % SINE_DEPTH;
            z   = (rem << 15) / SINE_DEPTH;
            if (q[0])
            begin
                z = 64'd32768 - z;
            end
            z2 = (z * z) >> 15;
            t  = (SIN_C * z2) >> 15;
            t  = SIN_B - t;
            t  = (t * z2) >> 15;
            t  = SIN_A - t;
            t  = (t * z) >> 15;
            if (t > 64'd32767)
            begin
                t = 64'd32767;
            end
            tab[k] = (q >= 64'd2) ? 16'(64'd0 - t) : 16'(t);
        end
        return tab;
    endfunction

    localparam logic [SINE_DEPTH-1:0][15:0] SINE_TABLE = build_table();

    // registered read
    always_ff @(posedge clk)
    begin
        data <= signed'(SINE_TABLE[addr]);
    end

endmodule

// File: hw/rtl/fmvb_voice_ram.sv
module fmvb_voice_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] ram [DEPTH];
    logic             vld_reg [DEPTH];
    logic [WIDTH-1:0] data_q_reg;
    logic             vld_q_reg;

    // storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_q_reg <= ram[rd_addr];
        end
    end

    // per-entry valid bits, unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_q_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = vld_q_reg ? data_q_reg : '0;

endmodule

// File: hw/rtl/fm_voice_bank_mixer.sv
// Bank of VOICES two-operator FM voices mixed into one saturated 16-bit sample stream.
// Each input transaction carries a command in s_tuser: load writes a voice's phase steps
// and gain, trigger restarts a voice at full envelope, and neither gives a
// result; tick produces one sample on the master side with the clip flag in m_tuser.
// Voices are processed one after another through a single sine ROM port and a single
// operator multiplier, each voice taking states ENV, MMUL, OFF, ANG, CMUL, GAIN, ACC;
// then MIX applies the output gain and SAT clips. Voice state and parameters live in two
// single-port-read RAMs with per-entry valid bits, so no clearing pass follows reset.
// A finished sample waits in the output register while the next command is accepted.
module fm_voice_bank_mixer #(
    parameter int VOICES     = 32,
    parameter int SINE_DEPTH = 1024,
    parameter int PHASE_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    // voice [4:0], mod_increment [28:5], car_increment [52:29], voice_gain_in [69:53]
    input  logic [71:0] s_tdata,
    // cmd [1:0]
    input  logic [1:0]  s_tuser,
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    // sample [15:0]
    output logic [15:0] m_tdata,
    // clipped [0]
    output logic [0:0]  m_tuser,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fmvb_pkg::*;

    localparam int AW      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int IDX_W   = $clog2(SINE_DEPTH);
    localparam int PIDX_W  = PHASE_BITS + 17;
    localparam int OFF_SH  = 47 - PHASE_BITS;
    localparam int SUM_W   = 33 + $clog2(VOICES);
    localparam int MIX_W   = SUM_W + 15;
    localparam int MAG_W   = MIX_W - 32;

    typedef struct packed {
        logic [ENV_W-1:0]      mod_env;
        logic [ENV_W-1:0]      car_env;
        logic [PHASE_BITS-1:0] mod_phase;
        logic [PHASE_BITS-1:0] car_phase;
    } voice_state_t;

    typedef struct packed {
        logic [GAIN_W-1:0]     gain;
        logic [PHASE_BITS-1:0] mod_step;
        logic [PHASE_BITS-1:0] car_step;
    } voice_param_t;

    // sine table index of a phase
    function automatic logic [IDX_W-1:0] phase_index(input logic [PHASE_BITS-1:0] ph);
        logic [PIDX_W-1:0] prod;
        prod = PIDX_W'(ph) * PIDX_W'(SINE_DEPTH);
        return prod[PHASE_BITS +: IDX_W];
    endfunction

    // configuration registers
    logic [24:0] env_step_mod_reg;
    logic [24:0] env_step_car_reg;
    logic [15:0] output_gain_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_step_mod_reg <= ENV_STEP_MOD_RST;
            env_step_car_reg <= ENV_STEP_CAR_RST;
            output_gain_reg  <= OUTPUT_GAIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ENV_STEP_MOD: env_step_mod_reg <= pwdata[24:0];
                REG_ENV_STEP_CAR: env_step_car_reg <= pwdata[24:0];
                REG_OUTPUT_GAIN:  output_gain_reg  <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_ENV_STEP_MOD: prdata = 32'(env_step_mod_reg);
            REG_ENV_STEP_CAR: prdata = 32'(env_step_car_reg);
            REG_OUTPUT_GAIN:  prdata = 32'(output_gain_reg);
            default:          prdata = '0;
        endcase
    end

    // input transaction fields
    cmd_t              in_cmd;
    logic [4:0]        in_voice;
    logic [23:0]       in_mod_inc;
    logic [23:0]       in_car_inc;
    logic [GAIN_W-1:0] in_gain;
    logic              in_accept;
    logic              voice_ok;

    assign in_cmd     = cmd_t'(s_tuser);
    assign in_voice   = s_tdata[4:0];
    assign in_mod_inc = s_tdata[28:5];
    assign in_car_inc = s_tdata[52:29];
    assign in_gain    = s_tdata[69:53];
    assign in_accept  = s_tvalid & s_tready;
    assign voice_ok   = 32'(in_voice) < VOICES;

    // sequencer and datapath registers
    state_t                   state_reg;
    state_t                   state_next;
    logic [AW-1:0]            voice_cnt_reg;
    logic [AW-1:0]            voice_cnt_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;

    logic [ENV_W-1:0]         mod_env_reg;
    logic [ENV_W-1:0]         car_env_reg;
    logic [15:0]              opmag_reg;
    logic                     opneg_reg;
    logic [PHASE_BITS-1:0]    off_reg;
    logic [32:0]              term_mag_reg;
    logic                     term_neg_reg;
    logic [MIX_W-1:0]         mix_mag_reg;
    logic                     mix_neg_reg;
    logic [15:0]              sample_reg;
    logic                     clip_reg;

    // memory ports
    voice_state_t             st_rd;
    voice_state_t             st_wr;
    voice_param_t             pr_rd;
    voice_param_t             pr_wr;
    logic                     st_we;
    logic                     pr_we;
    logic [AW-1:0]            st_waddr;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;

    // sine ROM port
    logic [IDX_W-1:0]         rom_addr;
    logic signed [15:0]       rom_data;

    fmvb_voice_ram #(
        .WIDTH ($bits(voice_state_t)),
        .DEPTH (VOICES)
    ) u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (st_rd)
    );

    fmvb_voice_ram #(
        .WIDTH ($bits(voice_param_t)),
        .DEPTH (VOICES)
    ) u_param_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (pr_we),
        .wr_addr (AW'(in_voice)),
        .wr_data (pr_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (pr_rd)
    );

    fmvb_sine_rom #(
        .SINE_DEPTH (SINE_DEPTH)
    ) u_sine_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // envelope decay, saturating at zero
    logic [ENV_W-1:0] mod_env_next;
    logic [ENV_W-1:0] car_env_next;

    assign mod_env_next = (st_rd.mod_env > env_step_mod_reg) ?
                          st_rd.mod_env - env_step_mod_reg : '0;
    assign car_env_next = (st_rd.car_env > env_step_car_reg) ?
                          st_rd.car_env - env_step_car_reg : '0;

    // operator: |sine| times envelope, sign kept aside
    logic [15:0]      sine_mag;
    logic [ENV_W-1:0] op_env;
    logic [40:0]      op_prod;

    assign sine_mag = rom_data[15] ? 16'(-rom_data) : 16'(rom_data);
    assign op_env   = (state_reg == S_CMUL) ? car_env_reg : mod_env_reg;
    assign op_prod  = 41'(sine_mag) * 41'(op_env);

    // modulator output turned into a phase offset
    logic [46:0]           am_full;
    logic [PHASE_BITS-1:0] am;
    logic [PHASE_BITS-1:0] off_next;

    assign am_full  = 47'(opmag_reg) * 47'(INV_TWO_PI_Q32);
    assign am       = am_full[OFF_SH +: PHASE_BITS];
    assign off_next = opneg_reg ? PHASE_BITS'(0) - am : am;

    // carrier angle and ROM address
    logic [PHASE_BITS-1:0] angle;

    assign angle    = st_rd.car_phase + off_reg;
    assign rom_addr = (state_reg == S_ANG) ? phase_index(angle) : phase_index(st_rd.mod_phase);

    // voice term and mix
    logic [32:0]             term_mag_next;
    logic signed [SUM_W-1:0] term_ext;
    logic [SUM_W-2:0]        sum_abs;
    logic [MIX_W-1:0]        mix_mag_next;

    assign term_mag_next = 33'(opmag_reg) * 33'(pr_rd.gain);
    assign term_ext      = signed'(SUM_W'(term_mag_reg));
    assign sum_abs       = sum_reg[SUM_W-1] ? (SUM_W-1)'(-sum_reg) : (SUM_W-1)'(sum_reg);
    assign mix_mag_next  = MIX_W'(sum_abs) * MIX_W'(output_gain_reg);

    // final truncation and saturation
    logic [MAG_W-1:0] mix_mag_hi;
    logic [15:0]      sample_next;
    logic             clip_next;

    assign mix_mag_hi = mix_mag_reg[MIX_W-1:32];

    always_comb
    begin
        sample_next = '0;
        clip_next   = 1'b0;
        if (!mix_neg_reg)
        begin
            if (mix_mag_hi > MAG_W'(32767))
            begin
                sample_next = 16'h7FFF;
                clip_next   = 1'b1;
            end
            else
            begin
                sample_next = mix_mag_hi[15:0];
            end
        end
        else
        begin
            if (mix_mag_hi > MAG_W'(32768))
            begin
                sample_next = 16'h8000;
                clip_next   = 1'b1;
            end
            else
            begin
                sample_next = 16'd0 - mix_mag_hi[15:0];
            end
        end
    end

    // memory write and read requests
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = voice_cnt_reg;
        st_wr    = '0;
        pr_we    = 1'b0;
        pr_wr    = '0;
        rd_en    = 1'b0;
        rd_addr  = '0;

        // trigger restarts the voice, load writes its parameters
        if (state_reg == S_IDLE && in_accept && voice_ok)
        begin
            if (in_cmd == CMD_TRIGGER)
            begin
                st_we         = 1'b1;
                st_waddr      = AW'(in_voice);
                st_wr.mod_env = ENV_FULL;
                st_wr.car_env = ENV_FULL;
            end
            else if (in_cmd == CMD_LOAD)
            begin
                pr_we          = 1'b1;
                pr_wr.mod_step = PHASE_BITS'(in_mod_inc);
                pr_wr.car_step = PHASE_BITS'(in_car_inc);
                pr_wr.gain     = (in_gain > GAIN_MAX) ? GAIN_MAX : in_gain;
            end
        end

        // tick fetches voice zero on acceptance
        if (state_reg == S_IDLE && in_accept && in_cmd == CMD_TICK)
        begin
            rd_en = 1'b1;
        end

        // next voice fetched while the sum updates
        if (state_reg == S_ACC && voice_cnt_reg != AW'(VOICES - 1))
        begin
            rd_en   = 1'b1;
            rd_addr = voice_cnt_reg + AW'(1);
        end

        // write back decayed envelopes and advanced phases
        if (state_reg == S_GAIN)
        begin
            st_we           = 1'b1;
            st_wr.mod_env   = mod_env_reg;
            st_wr.car_env   = car_env_reg;
            st_wr.mod_phase = st_rd.mod_phase + pr_rd.mod_step;
            st_wr.car_phase = st_rd.car_phase + pr_rd.car_step;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        voice_cnt_next = voice_cnt_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;

        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && in_cmd == CMD_TICK)
                begin
                    state_next     = S_ENV;
                    voice_cnt_next = '0;
                    sum_next       = '0;
                end
            end
            S_ENV:  state_next = S_MMUL;
            S_MMUL: state_next = S_OFF;
            S_OFF:  state_next = S_ANG;
            S_ANG:  state_next = S_CMUL;
            S_CMUL: state_next = S_GAIN;
            S_GAIN: state_next = S_ACC;
            S_ACC:
            begin
                sum_next = term_neg_reg ? sum_reg - term_ext : sum_reg + term_ext;
                if (voice_cnt_reg == AW'(VOICES - 1))
                begin
                    state_next = S_MIX;
                end
                else
                begin
                    voice_cnt_next = voice_cnt_reg + AW'(1);
                    state_next     = S_ENV;
                end
            end
            S_MIX:  state_next = S_SAT;
            S_SAT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            voice_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            voice_cnt_reg <= voice_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (state_reg == S_ENV)
        begin
            mod_env_reg <= mod_env_next;
            car_env_reg <= car_env_next;
        end
        if (state_reg == S_MMUL || state_reg == S_CMUL)
        begin
            opmag_reg <= op_prod[39:24];
            opneg_reg <= rom_data[15];
        end
        if (state_reg == S_OFF)
        begin
            off_reg <= off_next;
        end
        if (state_reg == S_GAIN)
        begin
            term_mag_reg <= term_mag_next;
            term_neg_reg <= opneg_reg;
        end
        if (state_reg == S_MIX)
        begin
            mix_mag_reg <= mix_mag_next;
            mix_neg_reg <= sum_reg[SUM_W-1];
        end
        if (state_reg == S_SAT && (!out_valid_reg || m_tready))
        begin
            sample_reg <= sample_next;
            clip_reg   <= clip_next;
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = sample_reg;
    assign m_tuser[0] = clip_reg;

endmodule
